### src/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TFMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TFMT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/tfmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfmt_pkg;

    localparam int FINGERS       = 5;
    localparam int TAXELS        = 12;
    localparam int HISTORY_DEPTH = 8;

    localparam int IDX_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int MEM_DEPTH  = FINGERS * HISTORY_DEPTH;
    localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W      = 5;
    localparam int ROOT_STEPS = 22;
    localparam int ACC_W      = 21;
    localparam int SQ_W       = 44;
    localparam int P_W        = 19;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_SQ   = 8'b00000100,
        S_ROOT = 8'b00001000,
        S_PRES = 8'b00010000,
        S_LOAD = 8'b00100000,
        S_SORT = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    typedef struct packed {
        logic             cap;
        logic             mul_en;
        logic             sq_en;
        logic             root_en;
        logic             pres_en;
        logic             load_en;
        logic             sort_en;
        logic             out_load;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

    // q1.15 unit vector component, 17 bits so that +1.0 fits
    function automatic logic signed [16:0] unit_coef(input logic [3:0] idx,
                                                     input logic [1:0] axis);
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        begin
            x = '0;
            y = '0;
            z = '0;
            case (idx)
                4'd0:  begin x = -17'sd32768; end
                4'd1:  begin x = -17'sd13093; z = 17'sd30039; end
                4'd2:  begin x = -17'sd13093; z = 17'sd30039; end
                4'd3:  begin x = -17'sd32768; end
                4'd4:  begin x = -17'sd25780; y = 17'sd19764; z = 17'sd4306; end
                4'd5:  begin x = -17'sd10128; y = 17'sd15652; z = 17'sd26948; end
                4'd6:  begin y = 17'sd32768; end
                4'd7:  begin x = 17'sd10128; y = 17'sd15652; z = 17'sd26948; end
                4'd8:  begin x = 17'sd25780; y = 17'sd19764; z = 17'sd4306; end
                4'd9:  begin x = 17'sd32768; end
                4'd10: begin x = 17'sd13093; z = 17'sd30039; end
                4'd11: begin x = 17'sd13093; z = 17'sd30039; end
                default: begin x = '0; end
            endcase
            case (axis)
                2'd0:    unit_coef = x;
                2'd1:    unit_coef = y;
                default: unit_coef = z;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

### src/tfmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tfmt_ctrl import tfmt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_cnt   = '0;
                    n_state = i_stat.last ? S_SQ : S_IDLE;
                end
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_cnt   = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_en = 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PRES;
                end
            end
            S_PRES: begin
                o_cmd.pres_en = 1'b1;
                n_cnt   = '0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (r_cnt == CNT_W'(HISTORY_DEPTH)) begin
                    n_cnt   = '0;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.sort_en = 1'b1;
                if (r_cnt == CNT_W'(HISTORY_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_cnt = '0;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### src/tfmt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tfmt_dp import tfmt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_use_ext,
    input  logic [2:0]          i_finger,
    input  logic [3:0]          i_taxel_index,
    input  logic signed [15:0]  i_taxel_value,
    input  logic                i_last_taxel,
    input  logic signed [15:0]  i_external_force,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [2:0]          o_finger_out,
    output logic signed [19:0]  o_plain_sum,
    output logic [18:0]         o_weighted_magnitude,
    output logic [18:0]         o_pressure,
    output logic [18:0]         o_median_pressure
);

    // captured item
    logic [2:0]         r_finger;
    logic [3:0]         r_idx;
    logic signed [15:0] r_val;
    logic               r_last;
    logic signed [15:0] r_ext;

    logic [ACC_W-1:0] r_acc_p, r_acc_x, r_acc_y, r_acc_z;
    logic [SQ_W-1:0]  r_sqsum, r_n, r_res, r_bit;

    logic [P_W-1:0]     r_mem [MEM_DEPTH];
    logic               r_mem_vld [MEM_DEPTH];
    logic [P_W-1:0]     r_rdata;
    logic               r_rvld;
    logic [IDX_W-1:0]   r_wp [FINGERS];
    logic [P_W-1:0]     r_win [HISTORY_DEPTH];
    logic [P_W-1:0]     n_win [HISTORY_DEPTH];

    logic [2:0]         r_res_finger;
    logic signed [19:0] r_res_ps;
    logic [P_W-1:0]     r_res_mag, r_res_pres;

    logic                     w_fok, w_in_range;
    logic [1:0]               w_axis;
    logic signed [16:0]       w_coef;
    logic signed [32:0]       w_prod, w_round;
    logic signed [ACC_W-1:0]  w_sel;
    logic signed [2*ACC_W-1:0] w_sq;
    logic [SQ_W-1:0]          w_t;
    logic signed [ACC_W-1:0]  w_ps;
    logic [P_W-1:0]           w_mag, w_pres, w_med;
    logic [IDX_W-1:0]         w_wp, w_rd_k;
    logic [ADDR_W-1:0]        w_wr_addr, w_rd_addr;
    logic [P_W-1:0]           w_shift_in;

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    assign w_fok      = (32'(r_finger) < FINGERS);
    assign w_in_range = (32'(r_idx) < TAXELS);
    assign w_axis     = i_cmd.cnt[1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_finger <= i_finger;
            r_idx    <= i_taxel_index;
            r_val    <= i_taxel_value;
            r_last   <= i_last_taxel;
            r_ext    <= i_external_force;
        end
    end

    // one product per cycle, rounded to q8.8
    assign w_coef  = unit_coef(r_idx, w_axis);
    assign w_prod  = r_val * w_coef;
    assign w_round = (w_prod + 33'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_p <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_cmd.pres_en) begin
            r_acc_p <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_cmd.mul_en && w_in_range) begin
            case (w_axis)
                2'd0: begin
                    r_acc_x <= r_acc_x + w_round[ACC_W-1:0];
                    r_acc_p <= r_acc_p + ACC_W'(r_val);
                end
                2'd1:    r_acc_y <= r_acc_y + w_round[ACC_W-1:0];
                default: r_acc_z <= r_acc_z + w_round[ACC_W-1:0];
            endcase
        end
    end

    // sum of squares, then bitwise square root
    always_comb begin
        case (w_axis)
            2'd0:    w_sel = r_acc_x;
            2'd1:    w_sel = r_acc_y;
            default: w_sel = r_acc_z;
        endcase
    end
    assign w_sq = w_sel * w_sel;
    assign w_t  = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            if (w_axis == 2'd0) begin
                r_sqsum <= SQ_W'(unsigned'(w_sq));
            end else if (w_axis == 2'd1) begin
                r_sqsum <= r_sqsum + SQ_W'(unsigned'(w_sq));
            end else begin
                r_n   <= r_sqsum + SQ_W'(unsigned'(w_sq));
                r_res <= '0;
                r_bit <= SQ_W'(1) << 42;
            end
        end else if (i_cmd.root_en) begin
            if (r_n >= w_t) begin
                r_n   <= r_n - w_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign w_ps = r_acc_p;
    assign w_mag = (r_res > SQ_W'(524287)) ? {P_W{1'b1}} : r_res[P_W-1:0];
    always_comb begin
        if (!i_use_ext) begin
            w_pres = w_mag;
        end else if (r_ext > 16'sd0) begin
            w_pres = P_W'(unsigned'(r_ext));
        end else begin
            w_pres = '0;
        end
    end

    // history memory, one write and one registered read per cycle
    assign w_wp       = w_fok ? r_wp[r_finger] : '0;
    assign w_rd_k     = i_cmd.cnt[IDX_W-1:0];
    assign w_wr_addr  = ADDR_W'(32'(r_finger) * HISTORY_DEPTH + 32'(w_wp));
    assign w_rd_addr  = ADDR_W'(32'(r_finger) * HISTORY_DEPTH + 32'(w_rd_k));

    always_ff @(posedge i_clk) begin
        if (i_cmd.pres_en && w_fok) begin
            r_mem[w_wr_addr] <= w_pres;
        end
        if (i_cmd.load_en && w_fok && (32'(i_cmd.cnt) < HISTORY_DEPTH)) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) begin
                r_mem_vld[i] <= 1'b0;
            end
            for (int f = 0; f < FINGERS; f++) begin
                r_wp[f] <= '0;
            end
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.pres_en && w_fok) begin
                r_mem_vld[w_wr_addr] <= 1'b1;
                r_wp[r_finger] <= (32'(w_wp) == HISTORY_DEPTH - 1) ? '0
                                                                   : w_wp + IDX_W'(1);
            end
            if (i_cmd.load_en) begin
                r_rvld <= w_fok && (32'(i_cmd.cnt) < HISTORY_DEPTH) && r_mem_vld[w_rd_addr];
            end
        end
    end

    // window: shift in, then odd-even transposition sort
    assign w_shift_in = r_rvld ? r_rdata : '0;

    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            n_win[i] = r_win[i];
        end
        if (i_cmd.load_en && (i_cmd.cnt != '0)) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_win[HISTORY_DEPTH-1] = w_shift_in;
        end else if (i_cmd.sort_en) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                if ((i % 2) == int'(i_cmd.cnt[0]) && r_win[i] > r_win[i+1]) begin
                    n_win[i]   = r_win[i+1];
                    n_win[i+1] = r_win[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    generate
        if (HISTORY_DEPTH % 2 == 1) begin : g_odd
            assign w_med = r_win[HISTORY_DEPTH/2];
        end else begin : g_even
            logic [P_W:0] w_pair;
            assign w_pair = {1'b0, r_win[HISTORY_DEPTH/2-1]} + {1'b0, r_win[HISTORY_DEPTH/2]};
            assign w_med  = w_pair[P_W:1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.pres_en) begin
            r_res_finger <= r_finger;
            if (w_ps > 21'sd524287) begin
                r_res_ps <= 20'sd524287;
            end else if (w_ps < -21'sd524288) begin
                r_res_ps <= -20'sd524288;
            end else begin
                r_res_ps <= w_ps[19:0];
            end
            r_res_mag  <= w_mag;
            r_res_pres <= w_pres;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_finger_out         <= r_res_finger;
            o_plain_sum          <= r_res_ps;
            o_weighted_magnitude <= r_res_mag;
            o_pressure           <= r_res_pres;
            o_median_pressure    <= (32'(r_res_finger) < FINGERS) ? w_med : '0;
        end
    end

endmodule
`default_nettype wire

### src/taxel_force_median_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake              | payload
// in       | in        | i_in_valid / o_in_stall | finger, taxel index, value, last, ext force
// out      | out       | o_out_valid / i_out_stall | finger, sums, magnitude, pressure, median
// cfg      | in        | i_cfg_valid / o_cfg_ready | use_external_force
//
// a taxel item is a capture, then x, y, z products through one multiplier
// a last item adds squaring of x, y and z, 22 root iterations, 1 history write,
// HISTORY_DEPTH history reads into the window and HISTORY_DEPTH sort passes,
// then the result load
// the input stalls whenever the sequencer is busy; a waiting result does not block
// taxel items, only the next result load
// synchronous active-low reset clears control, accumulators and history valid bits
`include "assert_macros.svh"
module taxel_force_median_tracker_top import tfmt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_finger,
    input  logic [3:0]         i_taxel_index,
    input  logic signed [15:0] i_taxel_value,
    input  logic               i_last_taxel,
    input  logic signed [15:0] i_external_force,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_finger_out,
    output logic signed [19:0] o_plain_sum,
    output logic [18:0]        o_weighted_magnitude,
    output logic [18:0]        o_pressure,
    output logic [18:0]        o_median_pressure,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  r_use_ext;

    // config register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_ext <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_use_ext <= i_cfg_data;
        end
    end

    tfmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tfmt_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_use_ext            (r_use_ext),
        .i_finger             (i_finger),
        .i_taxel_index        (i_taxel_index),
        .i_taxel_value        (i_taxel_value),
        .i_last_taxel         (i_last_taxel),
        .i_external_force     (i_external_force),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_finger_out         (o_finger_out),
        .o_plain_sum          (o_plain_sum),
        .o_weighted_magnitude (o_weighted_magnitude),
        .o_pressure           (o_pressure),
        .o_median_pressure    (o_median_pressure)
    );

    // a new result only appears from a load
    `TFMT_ASSERT(a_rise_from_load, $rose(o_out_valid) |-> $past(w_cmd.out_load), "result without load")
    // a held result is never overwritten
    `TFMT_ASSERT(a_no_overwrite, w_cmd.out_load |-> !(o_out_valid && i_out_stall), "result overwritten")
    // no item is captured while the sequencer is busy
    `TFMT_ASSERT(a_cap_idle, w_cmd.cap |-> !o_in_stall, "capture while busy")
    // reset empties the output
    `TFMT_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
`default_nettype wire

### test/tb_taxel_force_median_tracker_top.sv
`timescale 1ns / 1ps
module tb_taxel_force_median_tracker_top;
    import tfmt_pkg::*;

    // result fields as the block presents them
    typedef struct packed {
        logic [2:0]  finger;
        logic [19:0] psum;
        logic [18:0] mag;
        logic [18:0] pres;
        logic [18:0] med;
    } t_frame_result;

    localparam int CYCLE_LIMIT = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_finger = '0;
    logic [3:0]         i_taxel_index = '0;
    logic signed [15:0] i_taxel_value = '0;
    logic               i_last_taxel = 1'b0;
    logic signed [15:0] i_external_force = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_finger_out;
    logic signed [19:0] o_plain_sum;
    logic [18:0]        o_weighted_magnitude;
    logic [18:0]        o_pressure;
    logic [18:0]        o_median_pressure;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;

    taxel_force_median_tracker_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_finger(i_finger), .i_taxel_index(i_taxel_index),
        .i_taxel_value(i_taxel_value), .i_last_taxel(i_last_taxel),
        .i_external_force(i_external_force),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_finger_out(o_finger_out), .o_plain_sum(o_plain_sum),
        .o_weighted_magnitude(o_weighted_magnitude), .o_pressure(o_pressure),
        .o_median_pressure(o_median_pressure),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the tracker state
    logic [20:0] sum_acc, x_acc, y_acc, z_acc;
    logic [18:0] history [FINGERS][HISTORY_DEPTH];
    int          wr_pos [FINGERS];
    logic        ext_sel;

    t_frame_result pending_frames[$];
    int errors = 0;
    int frames_seen = 0;
    int items_sent = 0;
    int cycles = 0;
    int hold_off = 0;      // long receiver hold-off, counted down in its own process
    bit random_stall = 1'b0;

    task automatic report_mismatch(input string what, input logic [19:0] got,
                                   input logic [19:0] want);
        $display("mismatch frame %0d %s: got %0h want %0h", frames_seen, what, got, want);
        errors++;
    endtask

    // unit vector component, q1.15 with +-1.0 exact
    function automatic int signed axis_coef(input int idx, input int axis);
        int signed v [12][3] = '{
            '{-32768, 0, 0}, '{-13093, 0, 30039}, '{-13093, 0, 30039},
            '{-32768, 0, 0}, '{-25780, 19764, 4306}, '{-10128, 15652, 26948},
            '{0, 32768, 0}, '{10128, 15652, 26948}, '{25780, 19764, 4306},
            '{32768, 0, 0}, '{13093, 0, 30039}, '{13093, 0, 30039}};
        if (idx >= 12) return 0;
        return v[idx][axis];
    endfunction

    // product rounded to q8.8, floor after adding half
    function automatic longint signed round_q15(input longint signed a, input int signed c);
        return (a * c + 16384) >>> 15;
    endfunction

    function automatic logic [18:0] floor_root(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 42;
        for (int i = 0; i < 22; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (r > 524287) ? 19'h7FFFF : r[18:0];
    endfunction

    function automatic logic [18:0] history_median(input int f);
        logic [18:0] s [HISTORY_DEPTH];
        logic [18:0] t;
        logic [19:0] m;
        for (int i = 0; i < HISTORY_DEPTH; i++) s[i] = history[f][i];
        for (int i = 0; i < HISTORY_DEPTH; i++)
            for (int j = 0; j + 1 < HISTORY_DEPTH - i; j++)
                if (s[j] > s[j+1]) begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
        if (HISTORY_DEPTH % 2) return s[HISTORY_DEPTH/2];
        m = {1'b0, s[HISTORY_DEPTH/2-1]} + {1'b0, s[HISTORY_DEPTH/2]};
        return m[19:1];
    endfunction

    task automatic predict_item(input int f, input int idx, input logic signed [15:0] v,
                                input bit last, input logic signed [15:0] ext);
        longint signed ps, x, y, z;
        logic [63:0] sq;
        t_frame_result r;
        if (idx < TAXELS) begin
            sum_acc = sum_acc + 21'(v);
            x_acc = x_acc + 21'(round_q15(v, axis_coef(idx, 0)));
            y_acc = y_acc + 21'(round_q15(v, axis_coef(idx, 1)));
            z_acc = z_acc + 21'(round_q15(v, axis_coef(idx, 2)));
        end
        if (!last) return;
        ps = longint'($signed(sum_acc));
        x = longint'($signed(x_acc));
        y = longint'($signed(y_acc));
        z = longint'($signed(z_acc));
        if (ps > 524287) ps = 524287;
        if (ps < -524288) ps = -524288;
        sq = x * x + y * y + z * z;
        r.finger = f[2:0];
        r.psum = ps[19:0];
        r.mag = floor_root(sq);
        r.pres = ext_sel ? ((ext > 0) ? 19'(ext) : 19'd0) : r.mag;
        r.med = '0;
        if (f < FINGERS) begin
            history[f][wr_pos[f]] = r.pres;
            wr_pos[f] = (wr_pos[f] + 1) % HISTORY_DEPTH;
            r.med = history_median(f);
        end
        pending_frames.push_back(r);
        sum_acc = '0; x_acc = '0; y_acc = '0; z_acc = '0;
    endtask

    // sender: one item, held until accepted
    task automatic send_taxel(input int f, input int idx, input logic signed [15:0] v,
                              input bit last, input logic signed [15:0] ext);
        i_in_valid       <= 1'b1;
        i_finger         <= f[2:0];
        i_taxel_index    <= idx[3:0];
        i_taxel_value    <= v;
        i_last_taxel     <= last;
        i_external_force <= ext;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(f, idx, v, last, ext);
        items_sent++;
    endtask

    task automatic idle_sender(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // random gap between items, taken a third of the time
    task automatic maybe_gap();
        if ($urandom_range(2) == 0) idle_sender($urandom_range(1, 12));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_ext_select(input bit sel);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sel;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ext_sel = sel;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'($urandom_range(0, 600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    // a frame of random content; full-length frames send taxels in order, shorter ones random indices
    task automatic send_frame(input int f, input int len, input bit burst);
        for (int t = 0; t < len; t++) begin
            send_taxel(f, (len == 12) ? t : $urandom_range(15), rand_value(),
                       t == len - 1, rand_value());
            if (!burst) maybe_gap();
        end
    endtask

    task automatic test_directed_extremes();
        // all twelve taxels at full positive scale, then full negative
        for (int t = 0; t < TAXELS; t++) send_taxel(0, t, 16'sh7FFF, t == TAXELS-1, 16'sh0);
        for (int t = 0; t < TAXELS; t++) send_taxel(1, t, -16'sh8000, t == TAXELS-1, 16'sh0);
        // indices past the table, mixed finger tags inside a frame
        send_taxel(2, 12, 16'sh1234, 0, 0);
        send_taxel(3, 15, -16'sh8000, 0, 0);
        send_taxel(4, 6, 16'sh0100, 1, 0);
        // finger beyond the last one leaves history alone
        send_taxel(7, 9, 16'sh0200, 1, 0);
        send_taxel(5, 3, -16'sh0001, 1, 16'sh7FFF);
        wait_drained();
    endtask

    task automatic test_external_force();
        write_ext_select(1'b1);
        send_taxel(0, 4, 16'sh0100, 1, 16'sh7FFF);
        send_taxel(1, 5, 16'sh0100, 1, -16'sh8000);   // negative force clamps to zero
        send_taxel(2, 7, 16'sh0100, 1, 16'sh0000);
        for (int i = 0; i < 20; i++) send_frame($urandom_range(7), $urandom_range(1, 12), 0);
        wait_drained();
        write_ext_select(1'b0);
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering items
        hold_off = 400;
        for (int i = 0; i < 10; i++) send_frame($urandom_range(4), 4, 1);
        wait_drained();
    endtask

    task automatic test_random_frames();
        for (int ph = 0; ph < 4; ph++) begin
            while (items_sent < 330 * (ph + 1)) begin
                if ($urandom_range(9) == 0)
                    // noise: random index and tag, random last
                    send_taxel($urandom_range(7), $urandom_range(15), rand_value(),
                               $urandom_range(3) == 0, rand_value());
                else if ($urandom_range(4) == 0)
                    send_frame($urandom_range(4), 12, 0);
                else
                    send_frame($urandom_range(5), $urandom_range(1, 6), $urandom_range(1));
                if ($urandom_range(29) == 0) begin
                    random_stall = ~random_stall;
                end
            end
            // close any open frame before touching the register
            send_taxel(0, 0, 16'sh0001, 1, 16'sh0001);
            wait_drained();
            write_ext_select(ph[0] == 1'b0);
        end
    endtask

    // receiver stall pattern: quiet stretches and busy stretches
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else if (random_stall) begin
            i_out_stall <= ($urandom_range(3) == 0);
        end else begin
            i_out_stall <= ($urandom_range(9) < 4);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected result finger", 20'(o_finger_out), 20'd0);
            end else begin
                w = pending_frames.pop_front();
                if (o_finger_out !== w.finger)
                    report_mismatch("finger", 20'(o_finger_out), 20'(w.finger));
                if (o_plain_sum !== w.psum) report_mismatch("plain_sum", o_plain_sum, w.psum);
                if (o_weighted_magnitude !== w.mag)
                    report_mismatch("magnitude", 20'(o_weighted_magnitude), 20'(w.mag));
                if (o_pressure !== w.pres)
                    report_mismatch("pressure", 20'(o_pressure), 20'(w.pres));
                if (o_median_pressure !== w.med)
                    report_mismatch("median", 20'(o_median_pressure), 20'(w.med));
            end
            frames_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[taxel_force_median_tracker_top] ERROR");
            $finish;
        end
    end

    initial begin
        sum_acc = '0; x_acc = '0; y_acc = '0; z_acc = '0;
        ext_sel = 1'b0;
        for (int f = 0; f < FINGERS; f++) begin
            wr_pos[f] = 0;
            for (int d = 0; d < HISTORY_DEPTH; d++) history[f][d] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_external_force();
        test_backpressure();
        test_random_frames();
        if (pending_frames.size() != 0) begin
            $display("%0d results never arrived", pending_frames.size());
            errors++;
        end
        $display("covered %0d taxel items and %0d frame results, both pressure sources,",
                 items_sent, frames_seen);
        $display("out-of-table indices, spare finger tags and a long output hold-off");
        if (errors == 0) begin
            $display("[taxel_force_median_tracker_top] OK");
        end else begin
            $display("[taxel_force_median_tracker_top] ERROR");
        end
        $finish;
    end

endmodule
